@@ hdl/great_circle_bearing_assert.svh @@
// assertion macros for the great circle bearing checker
// no dependencies
`ifndef GREAT_CIRCLE_BEARING_ASSERT_SVH
`define GREAT_CIRCLE_BEARING_ASSERT_SVH
// property that must hold at every clock when out of reset
`define GCB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// implication whose consequent is checked in the next cycle
`define GCB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) \
        else $error(msg);
`endif

@@ hdl/gcb_pkg.sv @@
// shared types, constants and helpers for the great circle bearing pipeline
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package gcb_pkg;
    localparam longint unsigned DegTurn = 64'd3600000000;
    localparam longint unsigned KQ32 = 64'd2608131496;
    localparam int unsigned MaxBearing = 36000;

    typedef logic [31:0] t_bang;

    // arctangent table in binary-angle units, one full turn is 2^32
    function automatic logic [31:0] atan_entry(input int i);
        logic [31:0] r;
        begin
            unique case (i)
                0: r = 32'd536870912;  1: r = 32'd316933406;
                2: r = 32'd167458907;  3: r = 32'd85004756;
                4: r = 32'd42667331;   5: r = 32'd21354465;
                6: r = 32'd10679838;   7: r = 32'd5340245;
                8: r = 32'd2670163;    9: r = 32'd1335087;
                10: r = 32'd667544;    11: r = 32'd333772;
                12: r = 32'd166886;    13: r = 32'd83443;
                14: r = 32'd41722;     15: r = 32'd20861;
                16: r = 32'd10430;     17: r = 32'd5215;
                18: r = 32'd2608;      19: r = 32'd1304;
                20: r = 32'd652;       21: r = 32'd326;
                22: r = 32'd163;       23: r = 32'd81;
                24: r = 32'd41;        25: r = 32'd20;
                26: r = 32'd10;        27: r = 32'd5;
                28: r = 32'd3;         29: r = 32'd1;
                30: r = 32'd1;
                default: r = 32'd0;
            endcase
            atan_entry = r;
        end
    endfunction
endpackage
`default_nettype wire

@@ hdl/gcb_rot_cell.sv @@
// one cordic rotation cell: sine/cosine of three angles advanced by one step
// depends on gcb_pkg
`timescale 1ns / 1ps
`default_nettype none
module gcb_rot_cell
    import gcb_pkg::*;
#(
    parameter int W = 36,
    parameter int STEP = 0
) (
    input  wire logic                i_clk,
    input  wire logic                i_en,
    input  wire logic signed [W-1:0] i_x [3],
    input  wire logic signed [W-1:0] i_y [3],
    input  wire logic signed [32:0]  i_z [3],
    output logic signed [W-1:0]      o_x [3],
    output logic signed [W-1:0]      o_y [3],
    output logic signed [32:0]       o_z [3]
);
    localparam logic signed [32:0] Atan = $signed({1'b0, atan_entry(STEP)});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                if (!i_z[k][32]) begin
                    o_x[k] <= i_x[k] - (i_y[k] >>> STEP);
                    o_y[k] <= i_y[k] + (i_x[k] >>> STEP);
                    o_z[k] <= i_z[k] - Atan;
                end else begin
                    o_x[k] <= i_x[k] + (i_y[k] >>> STEP);
                    o_y[k] <= i_y[k] - (i_x[k] >>> STEP);
                    o_z[k] <= i_z[k] + Atan;
                end
            end
        end
    end
endmodule
`default_nettype wire

@@ hdl/gcb_vec_cell.sv @@
// one cordic vectoring cell for atan2, one step per cell
// depends on gcb_pkg
`timescale 1ns / 1ps
`default_nettype none
module gcb_vec_cell
    import gcb_pkg::*;
#(
    parameter int W = 40,
    parameter int STEP = 0
) (
    input  wire logic                i_clk,
    input  wire logic                i_en,
    input  wire logic signed [W-1:0] i_x,
    input  wire logic signed [W-1:0] i_y,
    input  wire logic        [31:0]  i_z,
    input  wire logic                i_zero,
    output logic signed [W-1:0]      o_x,
    output logic signed [W-1:0]      o_y,
    output logic        [31:0]       o_z,
    output logic                     o_zero
);
    localparam logic [31:0] Atan = atan_entry(STEP);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_zero <= i_zero;
            if (i_y > 0) begin
                o_x <= i_x + (i_y >>> STEP);
                o_y <= i_y - (i_x >>> STEP);
                o_z <= i_z + Atan;
            end else begin
                o_x <= i_x - (i_y >>> STEP);
                o_y <= i_y + (i_x >>> STEP);
                o_z <= i_z - Atan;
            end
        end
    end
endmodule
`default_nettype wire

@@ hdl/gcb_mul.sv @@
// signed fixed-point multiply, magnitude rounded half up, one register stage
// depends on gcb_pkg
`timescale 1ns / 1ps
`default_nettype none
module gcb_mul
    import gcb_pkg::*;
#(
    parameter int W = 36,
    parameter int FRAC = 30
) (
    input  wire logic                i_clk,
    input  wire logic                i_en,
    input  wire logic signed [W-1:0] i_a,
    input  wire logic signed [W-1:0] i_b,
    output logic signed [W-1:0]      o_p
);
    logic [W-1:0]   a_mag;
    logic [W-1:0]   b_mag;
    logic [2*W-1:0] prod;
    logic [2*W-1:0] rnd;
    logic [W-1:0]   mag;
    logic           neg;

    always_comb begin
        neg   = i_a[W-1] ^ i_b[W-1];
        a_mag = i_a[W-1] ? W'(-i_a) : W'(i_a);
        b_mag = i_b[W-1] ? W'(-i_b) : W'(i_b);
        prod  = {{W{1'b0}}, a_mag} * {{W{1'b0}}, b_mag};
        rnd   = prod + ((2*W)'(1) << (FRAC - 1));
        mag   = W'(rnd >> FRAC);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_p <= neg ? W'(-$signed(mag)) : $signed(mag);
        end
    end
endmodule
`default_nettype wire

@@ hdl/great_circle_bearing.sv @@
// top level of the great circle bearing pipeline
// depends on gcb_pkg, gcb_rot_cell, gcb_mul, gcb_vec_cell
//
// usage:
//  - input channel i_valid / o_stall carries one word: two positions as
//    latitude and longitude in 1e-7 degree units
//  - output channel o_valid / i_stall carries the bearing from the first
//    position to the second, in hundredths of a degree clockwise from north
//  - the datapath is a row of cordic cells: CORDIC_STEPS rotation cells
//    (capped at 32) produce sin/cos of both latitudes and the longitude
//    difference, three multiply stages form x and y, then as many
//    vectoring cells take atan2, and a final stage scales to centidegrees
//  - one word is accepted every cycle while o_stall is low; the whole
//    row advances together
//  - when the receiver stalls with a result waiting, the row freezes and
//    o_stall follows i_stall, so nothing is dropped; the output register
//    holds its word steady meanwhile
//  - reset clears every stage valid bit; payload registers are not reset
//  - coinciding points and a zero x,y vector give a bearing of zero
`timescale 1ns / 1ps
`default_nettype none
module great_circle_bearing
    import gcb_pkg::*;
#(
    parameter int CORDIC_STEPS = 24,
    parameter int FRAC_BITS = 30
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [30:0] i_from_lat,
    input  wire logic signed [31:0] i_from_lon,
    input  wire logic signed [30:0] i_to_lat,
    input  wire logic signed [31:0] i_to_lon,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [15:0]             o_bearing_centideg
);
    // sin/cos width: sign, one integer bit for cordic gain, guard bits
    localparam int W = FRAC_BITS + 4;
    localparam int N = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    // stages: angle 4, quadrant 1, rot N, mul 3, atan pre 1, vec N, out 1
    localparam int LAT = 2 * N + 10;
    localparam logic [W-1:0] KStart = (FRAC_BITS >= 32) ?
        W'(KQ32 << (FRAC_BITS - 32)) :
        W'((KQ32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));

    logic en;
    logic [LAT-1:0] r_vld;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // ---------------- stages 1 to 4: degrees to binary angle
    // one turn is 3.6e9 = 2^10 * 3515625; the ten low bits drop out, the
    // quotient comes from a reciprocal estimate that is short by at most
    // two and is fixed up from the remainder
    localparam longint unsigned TurnDiv = DegTurn >> 10;
    localparam longint unsigned TurnHalf = 64'd1800000000 >> 10;
    localparam logic [32:0] TurnRecip = 33'((64'd1 << 54) / TurnDiv);

    // reduce into one turn
    function automatic logic [31:0] wrap_turn(input logic signed [33:0] d);
        logic signed [34:0] m;
        begin
            m = 35'(d);
            if (m < 0) m = m + 35'(DegTurn);
            if (m < 0) m = m + 35'(DegTurn);
            if (m >= 35'(DegTurn)) m = m - 35'(DegTurn);
            wrap_turn = m[31:0];
        end
    endfunction

    logic [31:0] r_m [3];
    logic        r_same1;
    logic signed [33:0] dlon;
    assign dlon = 34'(i_to_lon) - 34'(i_from_lon);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m[0]  <= wrap_turn(34'(i_from_lat));
            r_m[1]  <= wrap_turn(34'(i_to_lat));
            r_m[2]  <= wrap_turn(dlon);
            r_same1 <= (i_from_lat == i_to_lat) &&
                       (dlon == 0 || dlon == 34'(DegTurn) || dlon == -34'(DegTurn));
        end
    end

    // quotient estimate
    logic [64:0] qe_prod [3];
    logic [31:0] r_qe [3];
    logic [31:0] r_m2 [3];
    always_comb begin
        for (int k = 0; k < 3; k++) qe_prod[k] = 65'(r_m[k]) * 65'(TurnRecip);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_qe[k] <= 32'(qe_prod[k] >> 32);
                r_m2[k] <= r_m[k];
            end
        end
    end

    // remainder, below three divisors
    logic [53:0] rem_full [3];
    logic [23:0] r_rem [3];
    logic [31:0] r_qe2 [3];
    always_comb begin
        for (int k = 0; k < 3; k++)
            rem_full[k] = {r_m2[k], 22'd0} + 54'(TurnHalf) - 54'(r_qe[k]) * 54'(TurnDiv);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_rem[k] <= 24'(rem_full[k]);
                r_qe2[k] <= r_qe[k];
            end
        end
    end

    // fix up the quotient, a full turn wraps to zero
    logic [1:0]  ang_fix [3];
    logic [31:0] r_ang [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            priority if (r_rem[k] >= 24'(2 * TurnDiv)) ang_fix[k] = 2'd2;
            else if (r_rem[k] >= 24'(TurnDiv)) ang_fix[k] = 2'd1;
            else ang_fix[k] = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) r_ang[k] <= r_qe2[k] + 32'(ang_fix[k]);
        end
    end

    // ---------------- quadrant fold
    logic [1:0] r_q [3];
    logic signed [W-1:0]  rx [N+1][3];
    logic signed [W-1:0]  ry [N+1][3];
    logic signed [32:0]   rz [N+1][3];
    logic r_same [LAT-2];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                logic [1:0] q;
                logic [31:0] r;
                q = 2'((r_ang[k] + 32'h2000_0000) >> 30);
                r = r_ang[k] - {q, 30'd0};
                r_q[k] <= q;
                rx[0][k] <= $signed(KStart);
                ry[0][k] <= '0;
                rz[0][k] <= {r[31], r};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_same[0] <= r_same1;
            for (int s = 1; s < LAT - 2; s++) r_same[s] <= r_same[s-1];
        end
    end

    logic [1:0] r_qd [N][3];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_qd[0] <= r_q;
            for (int s = 1; s < N; s++) r_qd[s] <= r_qd[s-1];
        end
    end

    for (genvar s = 0; s < N; s++) begin : g_rot
        gcb_rot_cell #(.W(W), .STEP(s)) u_cell (
            .i_clk(i_clk), .i_en(en),
            .i_x(rx[s]), .i_y(ry[s]), .i_z(rz[s]),
            .o_x(rx[s+1]), .o_y(ry[s+1]), .o_z(rz[s+1])
        );
    end

    // quadrant unfold: cos and sin per angle
    logic signed [W-1:0] c [3];
    logic signed [W-1:0] sn [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            unique case (r_qd[N-1][k])
                2'd0: begin c[k] = rx[N][k];  sn[k] = ry[N][k];  end
                2'd1: begin c[k] = -ry[N][k]; sn[k] = rx[N][k];  end
                2'd2: begin c[k] = -rx[N][k]; sn[k] = -ry[N][k]; end
                default: begin c[k] = ry[N][k]; sn[k] = -rx[N][k]; end
            endcase
        end
    end

    // ---------------- multiplies: three stages
    logic signed [W-1:0] m_y, m_a, m_b, m_bc;
    logic signed [W-1:0] r_cd;
    gcb_mul #(.W(W), .FRAC(FRAC_BITS)) u_my (.i_clk(i_clk), .i_en(en),
        .i_a(sn[2]), .i_b(c[1]), .o_p(m_y));
    gcb_mul #(.W(W), .FRAC(FRAC_BITS)) u_ma (.i_clk(i_clk), .i_en(en),
        .i_a(c[0]), .i_b(sn[1]), .o_p(m_a));
    gcb_mul #(.W(W), .FRAC(FRAC_BITS)) u_mb (.i_clk(i_clk), .i_en(en),
        .i_a(sn[0]), .i_b(c[1]), .o_p(m_b));
    always_ff @(posedge i_clk) begin
        if (en) r_cd <= c[2];
    end
    gcb_mul #(.W(W), .FRAC(FRAC_BITS)) u_mc (.i_clk(i_clk), .i_en(en),
        .i_a(m_b), .i_b(r_cd), .o_p(m_bc));

    logic signed [W-1:0] r_y2, r_a2;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_y2 <= m_y;
            r_a2 <= m_a;
        end
    end

    localparam int VW = W + 3;
    logic signed [VW-1:0] r_x3, r_y3;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_y3 <= VW'(r_y2);
            r_x3 <= VW'(r_a2) - VW'(m_bc);
        end
    end

    // ---------------- atan2 pre-rotation
    logic signed [VW-1:0] vx [N+1];
    logic signed [VW-1:0] vy [N+1];
    logic [31:0]          vz [N+1];
    logic                 vzero [N+1];
    always_ff @(posedge i_clk) begin
        if (en) begin
            vzero[0] <= (r_x3 == 0) && (r_y3 == 0);
            if (r_x3 < 0) begin
                vx[0] <= -r_x3;
                vy[0] <= -r_y3;
                vz[0] <= 32'h8000_0000;
            end else begin
                vx[0] <= r_x3;
                vy[0] <= r_y3;
                vz[0] <= '0;
            end
        end
    end

    for (genvar s = 0; s < N; s++) begin : g_vec
        gcb_vec_cell #(.W(VW), .STEP(s)) u_cell (
            .i_clk(i_clk), .i_en(en),
            .i_x(vx[s]), .i_y(vy[s]), .i_z(vz[s]), .i_zero(vzero[s]),
            .o_x(vx[s+1]), .o_y(vy[s+1]), .o_z(vz[s+1]), .o_zero(vzero[s+1])
        );
    end

    // ---------------- scale to centidegrees
    logic [47:0] cd_full;
    logic [15:0] cd_val;
    assign cd_full = 48'(vz[N]) * 48'(MaxBearing) + 48'h8000_0000;
    assign cd_val  = 16'(cd_full >> 32);

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_same[LAT-3] || vzero[N] || cd_val >= 16'(MaxBearing))
                o_bearing_centideg <= '0;
            else
                o_bearing_centideg <= cd_val;
        end
    end
endmodule
`default_nettype wire

@@ hdl/gcb_checker.sv @@
// port-level checker for great_circle_bearing, bound to the top level
// depends on great_circle_bearing_assert.svh
`timescale 1ns / 1ps
`default_nettype none
`include "great_circle_bearing_assert.svh"
module gcb_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [15:0] o_bearing_centideg
);
    `GCB_ASSERT(a_range, i_clk, i_rst_n, (!o_valid || o_bearing_centideg < 16'd36000), "bearing out of range")
    `GCB_ASSERT(a_stall_cause, i_clk, i_rst_n, (!o_stall || (o_valid && i_stall)), "stall without blocked output")
    `GCB_ASSERT_NEXT(a_hold, i_clk, i_rst_n, (o_valid && i_stall), (o_valid && $stable(o_bearing_centideg)), "stalled word changed")
endmodule
bind great_circle_bearing gcb_checker u_gcb_checker (.*);
`default_nettype wire
